FILE: rtl/ptmk_pkg.sv
// Shared constants and stage types for the point-to-Morton-key pipeline.
package ptmk_pkg;

   localparam int TREE_DEPTH = 16;
   localparam int COORD_W    = 32;
   localparam int EXT_W      = 31;
   localparam int REM_W      = EXT_W + 1;
   localparam int KEY_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   // key levels that fit into the output key
   localparam int KEY_LEVELS = (TREE_DEPTH < KEY_W / 2) ? TREE_DEPTH : KEY_W / 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_EXTENT_X = 2'd2,
      CSR_EXTENT_Y = 2'd3
   } csr_index_type;

   // payload carried between pipeline stages
   typedef struct packed {
      logic [REM_W-1:0]      rem_x;
      logic [REM_W-1:0]      rem_y;
      logic [TREE_DEPTH-1:0] quo_x;
      logic [TREE_DEPTH-1:0] quo_y;
      logic                  bad;
   } stage_type;

endpackage

FILE: rtl/point_to_morton_key.sv
// Top level: config registers, divider cell row and Morton key output stage.
//
// Maps a signed 2-D point to a Z-order key: each axis is offset by its origin,
// scaled to floor(offset * 2^(TREE_DEPTH-1) / extent) and the two indices are
// bit-interleaved, x above y, with the key truncated to 32 bits. A point outside
// [origin, origin + extent] on either axis, or any point when an extent is zero,
// returns key 0 with out_of_domain set. One point is accepted per cycle unless
// req_stall is high. The pipeline is one offset stage, one restoring-division cell
// per quotient bit for both axes in parallel, and the output register. Stages
// advance independently, so empty slots close up while the output is stalled.
// Configuration writes take effect at once and are not held back, so write the
// registers only while no point is in flight.
module point_to_morton_key
   import ptmk_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [KEY_W-1:0]          rsp_zorder_key,
   output logic                      rsp_out_of_domain
);

   logic signed [COORD_W-1:0] origin_x_ff;
   logic signed [COORD_W-1:0] origin_y_ff;
   logic [EXT_W-1:0]          extent_x_ff;
   logic [EXT_W-1:0]          extent_y_ff;

   logic                      stage_valid [0:TREE_DEPTH];
   stage_type                 stage_data  [0:TREE_DEPTH];
   logic                      stage_en    [0:TREE_DEPTH+1];

   logic                      rsp_valid_ff;
   logic [KEY_W-1:0]          key_ff;
   logic                      bad_ff;
   logic [KEY_W-1:0]          key_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         extent_x_ff <= EXT_W'(1);
         extent_y_ff <= EXT_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: origin_x_ff <= csr_write_data[COORD_W-1:0];
            CSR_ORIGIN_Y: origin_y_ff <= csr_write_data[COORD_W-1:0];
            CSR_EXTENT_X: extent_x_ff <= csr_write_data[EXT_W-1:0];
            CSR_EXTENT_Y: extent_y_ff <= csr_write_data[EXT_W-1:0];
            default: ;
         endcase
      end
   end

   ptmk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .extent_x  (extent_x_ff),
      .extent_y  (extent_y_ff),
      .down_en   (stage_en[1]),
      .up_en     (stage_en[0]),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   for (genvar k = 1; k <= TREE_DEPTH; k++) begin : g_cell
      ptmk_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k-1]),
         .in_data   (stage_data[k-1]),
         .extent_x  (extent_x_ff),
         .extent_y  (extent_y_ff),
         .down_en   (stage_en[k+1]),
         .up_en     (stage_en[k]),
         .out_valid (stage_valid[k]),
         .out_data  (stage_data[k])
      );
   end

   assign req_stall = !stage_en[0];

   // output register frees when empty or when its result transfers
   assign stage_en[TREE_DEPTH+1] = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      key_in = '0;
      for (int i = 0; i < KEY_LEVELS; i++) begin
         key_in[2*i+1] = stage_data[TREE_DEPTH].quo_x[i];
         key_in[2*i]   = stage_data[TREE_DEPTH].quo_y[i];
      end
      if (stage_data[TREE_DEPTH].bad) begin
         key_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_en[TREE_DEPTH+1]) begin
         rsp_valid_ff <= stage_valid[TREE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[TREE_DEPTH+1]) begin
         key_ff <= key_in;
         bad_ff <= stage_data[TREE_DEPTH].bad;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_zorder_key    = key_ff;
   assign rsp_out_of_domain = bad_ff;

endmodule

FILE: rtl/ptmk_front.sv
// Input stage: origin offset, domain check and divider seed for both axes.
module ptmk_front
   import ptmk_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  logic signed [COORD_W-1:0] origin_x,
   input  logic signed [COORD_W-1:0] origin_y,
   input  logic [EXT_W-1:0]          extent_x,
   input  logic [EXT_W-1:0]          extent_y,
   input  logic                      down_en,
   output logic                      up_en,
   output logic                      out_valid,
   output stage_type                 out_data
);

   logic              valid_ff;
   stage_type         data_ff;
   stage_type         data_in;
   logic [COORD_W:0]  off_x;
   logic [COORD_W:0]  off_y;
   logic              bad_x;
   logic              bad_y;

   assign up_en = !valid_ff || down_en;

   always_comb begin
      off_x = {point_x[COORD_W-1], point_x} - {origin_x[COORD_W-1], origin_x};
      off_y = {point_y[COORD_W-1], point_y} - {origin_y[COORD_W-1], origin_y};
      // negative offset, beyond the far edge, or empty axis
      bad_x = off_x[COORD_W] || (off_x[COORD_W-1:0] > {1'b0, extent_x}) ||
              (extent_x == '0);
      bad_y = off_y[COORD_W] || (off_y[COORD_W-1:0] > {1'b0, extent_y}) ||
              (extent_y == '0);
      data_in.bad   = bad_x || bad_y;
      data_in.rem_x = data_in.bad ? '0 : off_x[REM_W-1:0];
      data_in.rem_y = data_in.bad ? '0 : off_y[REM_W-1:0];
      data_in.quo_x = '0;
      data_in.quo_y = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/ptmk_cell.sv
// One restoring-division step: produces one quotient bit per axis.
module ptmk_cell
   import ptmk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  stage_type        in_data,
   input  logic [EXT_W-1:0] extent_x,
   input  logic [EXT_W-1:0] extent_y,
   input  logic             down_en,
   output logic             up_en,
   output logic             out_valid,
   output stage_type        out_data
);

   logic             valid_ff;
   stage_type        data_ff;
   stage_type        data_in;
   logic             bit_x;
   logic             bit_y;
   logic [REM_W-1:0] diff_x;
   logic [REM_W-1:0] diff_y;

   assign up_en = !valid_ff || down_en;

   // remainder entering a cell stays below twice the extent
   always_comb begin
      bit_x  = in_data.rem_x >= {1'b0, extent_x};
      bit_y  = in_data.rem_y >= {1'b0, extent_y};
      diff_x = bit_x ? in_data.rem_x - {1'b0, extent_x} : in_data.rem_x;
      diff_y = bit_y ? in_data.rem_y - {1'b0, extent_y} : in_data.rem_y;
      data_in.rem_x = {diff_x[REM_W-2:0], 1'b0};
      data_in.rem_y = {diff_y[REM_W-2:0], 1'b0};
      data_in.quo_x = {in_data.quo_x[TREE_DEPTH-2:0], bit_x};
      data_in.quo_y = {in_data.quo_y[TREE_DEPTH-2:0], bit_y};
      data_in.bad   = in_data.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sim/point_to_morton_key_checker.sv
// Scoreboard for point_to_morton_key: mirrors the domain registers and checks every result.
`timescale 1ns / 1ps
module point_to_morton_key_checker
   import ptmk_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [KEY_W-1:0]          rsp_zorder_key,
   input  logic                      rsp_out_of_domain,
   output int                        fail_count,
   output int                        pending
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             out_of_domain;
   } key_result_type;

   logic signed [COORD_W-1:0] origin_x;
   logic signed [COORD_W-1:0] origin_y;
   logic [EXT_W-1:0]          extent_x;
   logic [EXT_W-1:0]          extent_y;
   key_result_type            outstanding_keys[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                  input logic [KEY_W-1:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // cell index on one axis; false if ext is 0 or the point lies outside [org, org + ext]
   function automatic logic scale_coord(input logic signed [COORD_W-1:0] p,
                                        input logic signed [COORD_W-1:0] org,
                                        input logic [EXT_W-1:0] ext,
                                        output logic [63:0] idx);
      logic signed [63:0] off;
      off = $signed({{(64-COORD_W){p[COORD_W-1]}}, p})
          - $signed({{(64-COORD_W){org[COORD_W-1]}}, org});
      idx = '0;
      if (ext == '0 || off < 0 || off > $signed(64'(ext)))
         return 1'b0;
      idx = ($unsigned(off) << (TREE_DEPTH - 1)) / 64'(ext);
      return 1'b1;
   endfunction

   function automatic key_result_type predict_key(input logic signed [COORD_W-1:0] px,
                                                  input logic signed [COORD_W-1:0] py);
      logic [63:0]    cx;
      logic [63:0]    cy;
      logic           in_x;
      logic           in_y;
      key_result_type r;
      in_x = scale_coord(px, origin_x, extent_x, cx);
      in_y = scale_coord(py, origin_y, extent_y, cy);
      r = '0;
      if (in_x && in_y) begin
         // x above y per level; deep trees lose their upper levels
         for (int i = 0; i < KEY_W / 2; i++) begin
            r.key[2*i+1] = cx[i];
            r.key[2*i]   = cy[i];
         end
      end else begin
         r.out_of_domain = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         origin_x = '0;
         origin_y = '0;
         extent_x = EXT_W'(1);
         extent_y = EXT_W'(1);
         outstanding_keys.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_X: origin_x = csr_write_data;
               CSR_ORIGIN_Y: origin_y = csr_write_data;
               CSR_EXTENT_X: extent_x = csr_write_data[EXT_W-1:0];
               CSR_EXTENT_Y: extent_y = csr_write_data[EXT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (outstanding_keys.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding", rsp_zorder_key, '0);
            end else begin
               want = outstanding_keys.pop_front();
               if (rsp_zorder_key !== want.key)
                  report_mismatch("zorder_key", rsp_zorder_key, want.key);
               if (rsp_out_of_domain !== want.out_of_domain)
                  report_mismatch("out_of_domain", KEY_W'(rsp_out_of_domain),
                                  KEY_W'(want.out_of_domain));
            end
         end
         if (req_valid && !req_stall)
            outstanding_keys.insert(outstanding_keys.size(),
                                    predict_key(req_point_x, req_point_y));
      end
      pending = outstanding_keys.size();
   end

endmodule

FILE: sim/point_to_morton_key_tb.sv
// Testbench top for point_to_morton_key: directed and random points over changing domains.
`timescale 1ns / 1ps
module point_to_morton_key_tb;
   import ptmk_pkg::*;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = TREE_DEPTH + 20;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
   localparam logic [EXT_W-1:0]          EXT_MAX   = 31'h7fffffff;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index      = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_point_x    = '0;
   logic signed [COORD_W-1:0] req_point_y    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [KEY_W-1:0]          rsp_zorder_key;
   logic                      rsp_out_of_domain;

   int mismatch_count;
   int keys_outstanding;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_req       = 1'b0;

   // domain currently programmed, used to aim random points
   logic signed [COORD_W-1:0] dom_ox = '0;
   logic signed [COORD_W-1:0] dom_oy = '0;
   logic [EXT_W-1:0]          dom_ex = EXT_W'(1);
   logic [EXT_W-1:0]          dom_ey = EXT_W'(1);

   point_to_morton_key dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_zorder_key   (rsp_zorder_key),
      .rsp_out_of_domain(rsp_out_of_domain)
   );

   point_to_morton_key_checker key_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_zorder_key   (rsp_zorder_key),
      .rsp_out_of_domain(rsp_out_of_domain),
      .fail_count       (mismatch_count),
      .pending          (keys_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_req = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      // stall is settled mid-cycle; the transfer lands on the following edge
      @(negedge clock);
      while (req_stall) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (keys_outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_domain(input logic signed [COORD_W-1:0] ox,
                               input logic signed [COORD_W-1:0] oy,
                               input logic [EXT_W-1:0] ex,
                               input logic [EXT_W-1:0] ey);
      dom_ox = ox;
      dom_oy = oy;
      dom_ex = ex;
      dom_ey = ey;
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_ORIGIN_X;
      csr_write_data <= ox;
      @(posedge clock);
      csr_index      <= CSR_ORIGIN_Y;
      csr_write_data <= oy;
      @(posedge clock);
      csr_index      <= CSR_EXTENT_X;
      csr_write_data <= {1'b0, ex};
      @(posedge clock);
      csr_index      <= CSR_EXTENT_Y;
      csr_write_data <= {1'b0, ey};
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   function automatic logic [EXT_W-1:0] pick_extent();
      case ($urandom_range(3))
         0: return EXT_W'($urandom_range(16, 1));
         1: return EXT_W'($urandom_range(65535, 1));
         2: return EXT_W'($urandom | 1);
         default: return EXT_MAX;
      endcase
   endfunction

   // origin low enough that origin + extent stays representable
   function automatic logic signed [COORD_W-1:0] pick_origin(input logic [EXT_W-1:0] ext);
      logic [63:0] r;
      r = {$urandom, $urandom} % (64'd4294967296 - 64'(ext));
      return r[31:0] + 32'h80000000;
   endfunction

   // mostly inside the domain, some on or just outside its edges, a few anywhere
   function automatic logic signed [COORD_W-1:0] pick_coord(input logic signed [COORD_W-1:0] org,
                                                            input logic [EXT_W-1:0] ext);
      logic [63:0]  off;
      int unsigned  sel;
      sel = $urandom_range(99);
      if (sel < 70)      off = {$urandom, $urandom} % (64'(ext) + 64'd1);
      else if (sel < 80) off = '0;
      else if (sel < 88) off = 64'(ext);
      else if (sel < 92) off = 64'(ext) + 64'd1;
      else if (sel < 96) off = '1;
      else return $urandom;
      return org + off[COORD_W-1:0];
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset domain: origin 0, extent 1 on both axes
      send_point(0, 0);
      send_point(1, 1);
      send_point(1, 0);
      send_point(-1, 0);
      send_point(0, 2);
      send_point(COORD_MAX, COORD_MIN);
      drain();

      // widest domain from the bottom of the range
      write_domain(COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX);
      send_point(COORD_MIN, COORD_MIN);
      send_point(-1, -1);
      send_point(COORD_MAX, COORD_MAX);
      send_point(32'shC0000000, 0);
      send_point(-1, COORD_MIN);
      drain();

      // origin at the top of the range
      write_domain(COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX);
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MAX - 1);
      drain();

      write_domain(-1000, 2000, EXT_W'(4000), EXT_W'(3000));
      send_point(1000, 3500);
      send_point(3000, 5000);
      send_point(3001, 5000);
      send_point(-1000, 1999);
      drain();

      // zero extent empties the axis
      write_domain(-1000, 2000, EXT_W'(0), EXT_W'(3000));
      send_point(-1000, 2000);
      send_point(1000, 3500);
      drain();
      write_domain(-1000, 2000, EXT_W'(4000), EXT_W'(0));
      send_point(1000, 2000);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         logic [EXT_W-1:0] ex;
         logic [EXT_W-1:0] ey;
         send_idle_pct  = (ph < 3) ? 20 : (ph < 6) ? 70 : 0;
         recv_stall_pct = (ph < 3) ? 70 : (ph < 6) ? 20 : 0;
         ex = pick_extent();
         ey = pick_extent();
         write_domain(pick_origin(ex), pick_origin(ey), ex, ey);
         if (ph == RANDOM_PHASES - 2)
            hold_req = 1'b1;
         repeat (PHASE_ITEMS)
            send_point(pick_coord(dom_ox, dom_ex), pick_coord(dom_oy, dom_ey));
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && keys_outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
